@@ hdl/ftcwe_pkg.sv @@
// ============================================================================
// ftcwe_pkg
// Shared widths, constants, codes and types of the flux timestamp and
// cell width estimator.
// ============================================================================
`default_nettype none

package ftcwe_pkg;

    localparam int BINS      = 20;
    localparam int BIN_W     = $clog2(BINS);

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 32;
    localparam int SCALE_W   = 32;
    localparam int TS_W      = 32;
    localparam int BASE_W    = 48;
    localparam int RPM_W     = 16;
    localparam int CW_W      = 13;
    localparam int HIST_W    = 32;
    localparam int REQ_W     = 2;

    localparam int BIN_NS      = 500;
    localparam int HALF_BIN_NS = 250;
    localparam int SPAN        = BINS * BIN_NS;
    localparam int SPAN_W      = $clog2(SPAN);
    localparam int X_W         = TS_W + 1;

    // bin = x / 500 as x * RECIP >> DIV_SHIFT, exact for 0 <= x < SPAN
    localparam int DIV_SHIFT   = 26;
    localparam int RECIP       = (2 ** DIV_SHIFT + BIN_NS - 1) / BIN_NS;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int QPROD_W     = SPAN_W + RECIP_W;

    localparam int SRCH_LAST   = BINS / 2 - 1;

    localparam int DVD_W       = SCALE_W + RPM_W;
    localparam int QCNT_W      = $clog2(DVD_W);

    localparam logic [CFG_W-1:0]   NS_PER_COUNT_RESET = 32'd1638400;
    localparam logic [RPM_W-1:0]   NOMINAL_RPM_RESET  = 16'd30000;
    localparam logic [CFG_W-1:0]   CAPACITY_RESET     = 32'hFFFF_FFFF;
    localparam logic [CW_W-1:0]    DEFAULT_CW         = 13'd2000;

    typedef enum logic [REQ_W-1:0] {
        REQ_BEGIN = 2'd0,
        REQ_FLUX  = 2'd1,
        REQ_RPM   = 2'd2,
        REQ_END   = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NS_PER_COUNT = 2'd0,
        CFG_NOMINAL_RPM  = 2'd1,
        CFG_CAPACITY     = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_IV,
        S_BIN,
        S_HINC,
        S_HWAIT,
        S_DIV,
        S_SRCH,
        S_DONE
    } top_state_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_INC_WR,
        H_SRCH_A,
        H_SRCH_B,
        H_SRCH_C
    } hist_state_t;

    typedef struct packed {
        logic             clear;
        logic             inc;
        logic             search;
        logic [BIN_W-1:0] bin;
    } hist_cmd_t;

    typedef struct packed {
        logic            done;
        logic [CW_W-1:0] best_width;
    } hist_sts_t;

endpackage

`default_nettype wire

@@ hdl/ftcwe_ram.sv @@
// ============================================================================
// ftcwe_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module ftcwe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/ftcwe_div.sv @@
// ============================================================================
// ftcwe_div
// Restoring divider, one quotient bit per cycle, for the RPM rescale.
// ============================================================================
`default_nettype none

module ftcwe_div import ftcwe_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [RPM_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0]  quo_reg;
    logic [RPM_W-1:0]  rem_reg;
    logic [RPM_W-1:0]  div_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [RPM_W:0]    trial;
    logic [RPM_W:0]    diff;
    logic              ge;
    logic [RPM_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = (trial >= {1'b0, div_reg});
        rem_next = ge ? diff[RPM_W-1:0] : trial[RPM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (cnt_reg == QCNT_W'(DVD_W - 1)))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit out into the remainder, the quotient bit in
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + QCNT_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

`default_nettype wire

@@ hdl/ftcwe_hist.sv @@
// ============================================================================
// ftcwe_hist
// Interval histogram in RAM: saturating read-modify-write increments,
// per-entry valid bits for the begin clear, and the cell width search.
// ============================================================================
`default_nettype none

module ftcwe_hist import ftcwe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  hist_cmd_t cmd,
    output hist_sts_t sts
);

    hist_state_t       hstate_reg;
    hist_state_t       hstate_next;
    logic [BINS-1:0]   valid_reg;
    logic [BIN_W-1:0]  addr_reg;
    logic [BIN_W-1:0]  idx_reg;
    logic [HIST_W-1:0] a_reg;
    logic [HIST_W:0]   best_sum_reg;
    logic [CW_W-1:0]   best_width_reg;
    logic              done_reg;
    logic              rd_vld_reg;

    logic [BIN_W-1:0]  rd_addr;
    logic [HIST_W-1:0] rd_data;
    logic [HIST_W-1:0] masked;
    logic [HIST_W-1:0] wdata;
    logic              we;
    logic [BIN_W-1:0]  dbl;
    logic [HIST_W:0]   pair_sum;
    logic              last;
    logic [CW_W-1:0]   idx_width;

    ftcwe_ram #(
        .WIDTH (HIST_W),
        .DEPTH (BINS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (addr_reg),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        dbl       = {idx_reg[BIN_W-2:0], 1'b0};
        masked    = rd_vld_reg ? rd_data : '0;
        wdata     = (masked == '1) ? masked : masked + HIST_W'(1);
        pair_sum  = {1'b0, a_reg} + {1'b0, masked};
        last      = (idx_reg == BIN_W'(SRCH_LAST));
        idx_width = CW_W'(idx_reg) * CW_W'(BIN_NS);
    end

    always_comb
    begin
        hstate_next = hstate_reg;
        rd_addr     = cmd.bin;
        we          = 1'b0;
        case (hstate_reg)
            H_IDLE:
            begin
                if (cmd.inc)
                begin
                    hstate_next = H_INC_WR;
                end
                else if (cmd.search)
                begin
                    hstate_next = H_SRCH_A;
                end
            end
            H_INC_WR:
            begin
                we          = 1'b1;
                hstate_next = H_IDLE;
            end
            H_SRCH_A:
            begin
                rd_addr     = idx_reg;
                hstate_next = H_SRCH_B;
            end
            H_SRCH_B:
            begin
                rd_addr     = dbl;
                hstate_next = H_SRCH_C;
            end
            H_SRCH_C:
            begin
                hstate_next = last ? H_IDLE : H_SRCH_A;
            end
            default:
            begin
                hstate_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hstate_reg     <= H_IDLE;
            valid_reg      <= '0;
            best_width_reg <= DEFAULT_CW;
            done_reg       <= 1'b0;
        end
        else
        begin
            hstate_reg <= hstate_next;
            done_reg   <= (hstate_reg == H_INC_WR) || ((hstate_reg == H_SRCH_C) && last);
            if ((hstate_reg == H_IDLE) && cmd.clear)
            begin
                valid_reg      <= '0;
                best_width_reg <= DEFAULT_CW;
            end
            if (hstate_reg == H_INC_WR)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            // strictly larger only: ties keep the smallest index
            if ((hstate_reg == H_SRCH_C) && (pair_sum > best_sum_reg))
            begin
                best_width_reg <= idx_width;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_vld_reg <= valid_reg[rd_addr];
        case (hstate_reg)
            H_IDLE:
            begin
                addr_reg     <= cmd.bin;
                idx_reg      <= BIN_W'(1);
                best_sum_reg <= '0;
            end
            H_SRCH_B:
            begin
                a_reg <= masked;
            end
            H_SRCH_C:
            begin
                idx_reg <= idx_reg + BIN_W'(1);
                if (pair_sum > best_sum_reg)
                begin
                    best_sum_reg <= pair_sum;
                end
            end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

    assign sts.done       = done_reg;
    assign sts.best_width = best_width_reg;

endmodule

`default_nettype wire

@@ hdl/flux_timestamp_cell_width_estimator_top.sv @@
// ============================================================================
// flux_timestamp_cell_width_estimator_top
// Flux deltas to nanosecond timestamps with RPM rescaling, interval
// histogram and best bit cell width on end of stream.
// ============================================================================
// One transaction at a time. Begin and an over-capacity sample go straight
// to the result; a flux sample passes multiply, 48-bit add, interval, bin and
// histogram RAM read-modify-write, an RPM event the 48-step divider and an
// end the search (two RAM reads per bin). Results sit in an output register,
// so a new transaction enters while one waits. Reset is immediate:
// histogram entries are cleared by valid bits.
`default_nettype none

module flux_timestamp_cell_width_estimator_top import ftcwe_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [CNT_W-1:0]       delta,
    input  logic [RPM_W-1:0]       actual_rpm,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [REQ_W-1:0]       kind,
    output logic signed [TS_W-1:0] timestamp_ns,
    output logic                   stored,
    output logic                   overflow,
    output logic [CW_W-1:0]        cell_width_ns
);

    localparam logic signed [X_W-1:0] X_LO = X_W'(-BIN_NS);
    localparam logic signed [X_W-1:0] X_HI = X_W'(SPAN);

    top_state_t          state_reg;
    top_state_t          state_next;

    logic [CFG_W-1:0]    ns_cfg_reg;
    logic [RPM_W-1:0]    nom_cfg_reg;
    logic [CFG_W-1:0]    cap_cfg_reg;

    logic [BASE_W-1:0]   base_reg;
    logic [CNT_W-1:0]    counts_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [TS_W-1:0]     prev_reg;
    logic [CNT_W-1:0]    nstored_reg;

    req_t                kind_reg;
    logic [RPM_W-1:0]    rpm_reg;
    logic [BASE_W-1:0]   prod_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [TS_W-1:0]     ts_reg;
    logic signed [X_W-1:0] x_reg;
    logic [BIN_W-1:0]    bin_reg;

    logic [TS_W-1:0]     res_ts_reg;
    logic                res_stored_reg;
    logic                res_ovf_reg;
    logic [CW_W-1:0]     res_cw_reg;

    logic                out_valid_reg;
    req_t                out_kind_reg;
    logic [TS_W-1:0]     out_ts_reg;
    logic                out_stored_reg;
    logic                out_ovf_reg;
    logic [CW_W-1:0]     out_cw_reg;

    logic                accept;
    logic                out_load;
    logic                has_room;
    logic [2*SCALE_W-1:0] prod_full;
    logic [DVD_W-1:0]    dvd_full;
    logic [BASE_W-1:0]   sum48;
    logic [TS_W-1:0]     diff;
    logic [X_W-1:0]      x_next;
    logic                in_range;
    logic [QPROD_W-1:0]  q_prod;
    logic [BIN_W-1:0]    bin_calc;
    logic [RPM_W-1:0]    rpm_fix;
    logic [SCALE_W-1:0]  scale_sat;

    hist_cmd_t           hist_cmd;
    hist_sts_t           hist_sts;
    logic                div_start;
    logic                div_done;
    logic [DVD_W-1:0]    div_quo;

    ftcwe_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hist_cmd),
        .sts   (hist_sts)
    );

    ftcwe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (rpm_fix),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        accept    = in_valid && in_ready;
        out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
        has_room  = (nstored_reg < cap_cfg_reg);
        prod_full = counts_reg * scale_reg;
        dvd_full  = DVD_W'(ns_cfg_reg) * DVD_W'(nom_cfg_reg);
        sum48     = prod_reg + base_reg;
        diff      = ts_reg - prev_reg;
        x_next    = {diff[TS_W-1], diff} + X_W'(HALF_BIN_NS);
        // truncating division: anything above -500 rounds into bin zero
        in_range  = (x_reg > X_LO) && (x_reg < X_HI);
        q_prod    = QPROD_W'(x_reg[SPAN_W-1:0]) * QPROD_W'(RECIP);
        bin_calc  = x_reg[X_W-1] ? '0 : q_prod[DIV_SHIFT +: BIN_W];
        rpm_fix   = (rpm_reg == '0) ? RPM_W'(1) : rpm_reg;
        scale_sat = (div_quo[DVD_W-1:SCALE_W] != '0) ? '1 : div_quo[SCALE_W-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        hist_cmd     = '0;
        hist_cmd.bin = bin_reg;
        div_start    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_BEGIN:
                        begin
                            hist_cmd.clear = 1'b1;
                            state_next     = S_DONE;
                        end
                        REQ_FLUX:
                        begin
                            state_next = has_room ? S_MUL : S_DONE;
                        end
                        REQ_RPM:
                        begin
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            hist_cmd.search = 1'b1;
                            state_next      = S_SRCH;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (kind_reg == REQ_RPM)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_IV;
                end
            end
            S_IV:
            begin
                // the first sample of a run has no interval
                state_next = (nstored_reg == '0) ? S_DONE : S_BIN;
            end
            S_BIN:
            begin
                state_next = in_range ? S_HINC : S_DONE;
            end
            S_HINC:
            begin
                hist_cmd.inc = 1'b1;
                state_next   = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (hist_sts.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_SRCH:
            begin
                if (hist_sts.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ns_cfg_reg    <= NS_PER_COUNT_RESET;
            nom_cfg_reg   <= NOMINAL_RPM_RESET;
            cap_cfg_reg   <= CAPACITY_RESET;
            base_reg      <= '0;
            counts_reg    <= '0;
            scale_reg     <= NS_PER_COUNT_RESET;
            prev_reg      <= '0;
            nstored_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NS_PER_COUNT: ns_cfg_reg  <= cfg_data;
                    CFG_NOMINAL_RPM:  nom_cfg_reg <= cfg_data[RPM_W-1:0];
                    CFG_CAPACITY:     cap_cfg_reg <= cfg_data;
                    default:          ns_cfg_reg  <= ns_cfg_reg;
                endcase
            end

            if (accept && (req_type == REQ_BEGIN))
            begin
                base_reg    <= '0;
                counts_reg  <= '0;
                scale_reg   <= ns_cfg_reg;
                prev_reg    <= '0;
                nstored_reg <= '0;
            end
            else if (accept && (req_type == REQ_FLUX))
            begin
                counts_reg <= counts_reg + delta;
            end
            else if ((state_reg == S_ADD) && (kind_reg == REQ_RPM))
            begin
                // fold the time so far into the base
                base_reg   <= sum48;
                counts_reg <= '0;
            end
            else if (state_reg == S_IV)
            begin
                prev_reg    <= ts_reg;
                nstored_reg <= nstored_reg + CNT_W'(1);
            end
            else if ((state_reg == S_DIV) && div_done)
            begin
                scale_reg <= scale_sat;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg       <= req_t'(req_type);
            rpm_reg        <= actual_rpm;
            res_ts_reg     <= '0;
            res_stored_reg <= 1'b0;
            res_ovf_reg    <= (req_type == REQ_FLUX) && !has_room;
            res_cw_reg     <= '0;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_full[BASE_W-1:0];
            dvd_reg  <= dvd_full;
        end
        if (state_reg == S_ADD)
        begin
            ts_reg <= sum48[BASE_W-1 -: TS_W];
        end
        if (state_reg == S_IV)
        begin
            x_reg          <= signed'(x_next);
            res_ts_reg     <= ts_reg;
            res_stored_reg <= 1'b1;
        end
        if (state_reg == S_BIN)
        begin
            bin_reg <= bin_calc;
        end
        if ((state_reg == S_SRCH) && hist_sts.done)
        begin
            res_cw_reg <= hist_sts.best_width;
        end
        if (out_load)
        begin
            out_kind_reg   <= kind_reg;
            out_ts_reg     <= res_ts_reg;
            out_stored_reg <= res_stored_reg;
            out_ovf_reg    <= res_ovf_reg;
            out_cw_reg     <= res_cw_reg;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign timestamp_ns  = signed'(out_ts_reg);
    assign stored        = out_stored_reg;
    assign overflow      = out_ovf_reg;
    assign cell_width_ns = out_cw_reg;

    a_store_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(stored && overflow))
        else $error("result flagged both stored and overflow");

    a_ts_only_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !stored) |-> (timestamp_ns == '0))
        else $error("timestamp on a result that stored no sample");

    a_cw_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != REQ_END)) |-> (cell_width_ns == '0))
        else $error("cell width on a result other than end");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start work");

endmodule

`default_nettype wire

@@ tb/flux_timestamp_cell_width_estimator_top_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// flux_timestamp_cell_width_estimator_top_test
// Drives flux, RPM, begin and end transactions into the estimator. A local
// model of the timestamp scaling, interval histogram and cell width search
// predicts each result, and the results are compared field by field in order.
// Runs directed corner cases, register extremes, patterned random streams
// under several idle mixes, and a long output stall.
// ============================================================================

module flux_timestamp_cell_width_estimator_top_test;
    import ftcwe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [TS_W-1:0]  stamp;
        logic             stored;
        logic             overflow;
        logic [CW_W-1:0]  cell_width;
    } flux_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    req_t                 req_type;
    logic [CNT_W-1:0]     delta;
    logic [RPM_W-1:0]     actual_rpm;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [REQ_W-1:0]     kind;
    logic [TS_W-1:0]      timestamp_ns;
    logic                 stored;
    logic                 overflow;
    logic [CW_W-1:0]      cell_width_ns;

    // register copies and run state of the local model
    logic [CFG_W-1:0]  reg_ns_per_count;
    logic [RPM_W-1:0]  reg_nominal_rpm;
    logic [CFG_W-1:0]  reg_capacity;
    logic [BASE_W-1:0] run_base_q16;
    logic [CNT_W-1:0]  run_counts;
    logic [SCALE_W-1:0] run_scale_q16;
    logic [TS_W-1:0]   last_stamp;
    logic [CNT_W-1:0]  stamps_stored;
    logic [HIST_W-1:0] interval_bins [BINS];
    logic [CW_W-1:0]   cell_width_best;

    flux_result_t pending_results [$];
    int unsigned  reqs_sent = 0;
    int unsigned  fail_count = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    logic         hold_tog = 1'b0;
    logic         hold_seen = 1'b0;
    int unsigned  hold_left = 0;

    flux_timestamp_cell_width_estimator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .delta         (delta),
        .actual_rpm    (actual_rpm),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .timestamp_ns  (timestamp_ns),
        .stored        (stored),
        .overflow      (overflow),
        .cell_width_ns (cell_width_ns)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_run_state();
        run_base_q16    = '0;
        run_counts      = '0;
        run_scale_q16   = reg_ns_per_count;
        last_stamp      = '0;
        stamps_stored   = '0;
        foreach (interval_bins[b])
            interval_bins[b] = '0;
        cell_width_best = DEFAULT_CW;
    endfunction

    function automatic flux_result_t predict_flux_result(input req_t op,
                                                         input logic [CNT_W-1:0] d,
                                                         input logic [RPM_W-1:0] rpm);
        flux_result_t     res;
        logic [63:0]      acc;
        logic [TS_W-1:0]  step_ns;
        longint           span;
        longint           bin;
        logic [HIST_W:0]  sum;
        logic [HIST_W:0]  best_sum;
        logic [RPM_W-1:0] divisor;
        int               i;
        res = '0;
        res.kind = op;
        case (op)
            REQ_BEGIN:
                clear_run_state();
            REQ_FLUX:
            begin
                run_counts += d;
                if (stamps_stored < reg_capacity)
                begin
                    acc = 64'(run_counts) * 64'(run_scale_q16) + 64'(run_base_q16);
                    res.stamp = acc[47:16];
                    if (stamps_stored != 0)
                    begin
                        // interval rounds to the nearest half microsecond
                        step_ns = res.stamp - last_stamp;
                        span = $signed(step_ns);
                        bin = (span + HALF_BIN_NS) / BIN_NS;
                        if (bin >= 0 && bin < BINS && interval_bins[bin] != '1)
                            interval_bins[bin] = interval_bins[bin] + 1'b1;
                    end
                    last_stamp = res.stamp;
                    stamps_stored += 1'b1;
                    res.stored = 1'b1;
                end
                else
                    res.overflow = 1'b1;
            end
            REQ_RPM:
            begin
                // fold elapsed time into the base, then rescale
                acc = 64'(run_counts) * 64'(run_scale_q16) + 64'(run_base_q16);
                run_base_q16 = acc[47:0];
                run_counts = '0;
                divisor = (rpm == 0) ? 16'd1 : rpm;
                acc = (64'(reg_ns_per_count) * 64'(reg_nominal_rpm)) / 64'(divisor);
                run_scale_q16 = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
            end
            default:
            begin
                best_sum = '0;
                for (i = 1; i <= SRCH_LAST; i++)
                begin
                    sum = interval_bins[i];
                    sum += interval_bins[2 * i];
                    if (sum > best_sum)
                    begin
                        best_sum = sum;
                        cell_width_best = CW_W'(i * BIN_NS);
                    end
                end
                res.cell_width = cell_width_best;
            end
        endcase
        return res;
    endfunction

    // one transaction; valid stays high from here until the next gap
    task automatic send_req(input req_t op, input logic [CNT_W-1:0] d,
                            input logic [RPM_W-1:0] rpm);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        req_type   <= op;
        delta      <= d;
        actual_rpm <= rpm;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_flux_result(op, d, rpm));
        reqs_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_NS_PER_COUNT: reg_ns_per_count = value;
            CFG_NOMINAL_RPM:  reg_nominal_rpm  = value[RPM_W-1:0];
            CFG_CAPACITY:     reg_capacity     = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] ns_q16, input logic [RPM_W-1:0] nominal,
                            input logic [CFG_W-1:0] capacity);
        wait_idle();
        write_reg(CFG_NS_PER_COUNT, ns_q16);
        write_reg(CFG_NOMINAL_RPM, {16'd0, nominal});
        write_reg(CFG_CAPACITY, capacity);
    endtask

    // counts for a jittered interval of one to three cells at the current scale
    function automatic logic [CNT_W-1:0] pick_flux_delta(input int unsigned cell_units);
        int unsigned mult;
        int unsigned span_ns;
        logic [63:0] counts;
        mult = ($urandom_range(99) < 45) ? 1 : (($urandom_range(99) < 75) ? 2 : 3);
        span_ns = cell_units * BIN_NS * mult + $urandom_range(400);
        span_ns -= 200;
        if (run_scale_q16 == 0)
            return $urandom_range(1000);
        counts = (64'(span_ns) << 16) / run_scale_q16;
        return counts[CNT_W-1:0];
    endfunction

    task automatic send_noise();
        send_req(req_t'($urandom_range(3)), $urandom, RPM_W'($urandom));
    endtask

    task automatic run_stream();
        int unsigned cell_units;
        int unsigned n;
        int unsigned roll;
        int unsigned rpm;
        send_req(REQ_BEGIN, $urandom, RPM_W'($urandom));
        cell_units = $urandom_range(1, SRCH_LAST);
        n = $urandom_range(15, 45);
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
            begin
                rpm = reg_nominal_rpm * $urandom_range(97, 103) / 100;
                if (rpm == 0)
                    rpm = 1;
                if (rpm > 65535)
                    rpm = 65535;
                send_req(REQ_RPM, $urandom, RPM_W'(rpm));
            end
            else if (roll < 10)
                send_noise();
            else
                send_req(REQ_FLUX, pick_flux_delta(cell_units), RPM_W'($urandom));
        end
        send_req(REQ_END, $urandom, RPM_W'($urandom));
    endtask

    task automatic test_directed_events();
        send_req(REQ_BEGIN, '0, '0);
        send_req(REQ_FLUX, 32'd0, '0);          // first sample, no interval yet
        send_req(REQ_FLUX, 32'd20, '0);         // one half microsecond
        send_req(REQ_FLUX, 32'd40, '0);
        send_req(REQ_FLUX, 32'd30, '0);         // rounds up to the next bin
        send_req(REQ_FLUX, 32'd0, '0);          // zero interval
        send_req(REQ_FLUX, 32'hFFFF_FFFF, '1);  // count wraps, interval goes negative
        send_req(REQ_FLUX, 32'd1, '0);
        send_req(REQ_RPM, '0, 16'd0);           // zero RPM acts as one, scale saturates
        send_req(REQ_FLUX, 32'd1, '0);
        send_req(REQ_RPM, '0, 16'hFFFF);
        send_req(REQ_FLUX, 32'd100, '0);
        send_req(REQ_RPM, '1, 16'd30000);
        send_req(REQ_FLUX, 32'd20, '0);
        send_req(REQ_FLUX, 32'd40, '0);
        send_req(REQ_END, '0, '0);
        send_req(REQ_END, '1, '1);
        send_req(REQ_BEGIN, '1, '1);
        send_req(REQ_END, '0, '0);              // empty run keeps the default width
    endtask

    task automatic test_register_extremes();
        set_regs('1, 16'hFFFF, 32'd0);
        write_reg(CFG_UNUSED, $urandom);
        send_req(REQ_BEGIN, '0, '0);
        send_req(REQ_FLUX, 32'hFFFF_FFFF, '0);  // zero capacity flags it
        send_req(REQ_RPM, '0, 16'd1);
        send_req(REQ_END, '0, '0);
        set_regs(32'd1, 16'd1, 32'd2);
        send_req(REQ_BEGIN, '0, '0);
        send_req(REQ_FLUX, 32'd1, '0);
        send_req(REQ_FLUX, 32'hFFFF_FFFF, '0);
        send_req(REQ_FLUX, 32'd5, '0);          // beyond capacity
        send_req(REQ_RPM, '0, 16'hFFFF);        // scale rounds down to zero
        send_req(REQ_END, '0, '0);
        set_regs(NS_PER_COUNT_RESET, NOMINAL_RPM_RESET, CAPACITY_RESET);
    endtask

    task automatic test_random_streams();
        int p;
        int unsigned phase_goal;
        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    set_regs(NS_PER_COUNT_RESET, NOMINAL_RPM_RESET, CAPACITY_RESET);
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                    set_regs($urandom_range(65536, 6553600),
                             RPM_W'($urandom_range(1000, 65535)),
                             $urandom_range(8, 60));
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                    set_regs($urandom | 32'd1, RPM_W'($urandom_range(1, 65535)), $urandom);
                end
                default:
                begin
                    send_idle_pct = 37;
                    recv_stall_pct = 37;
                    set_regs(32'd655360, 16'hFFFF, CAPACITY_RESET);
                end
            endcase
            phase_goal = reqs_sent + 270;
            while (reqs_sent < phase_goal)
                run_stream();
        end
    endtask

    task automatic test_output_backpressure();
        set_regs(NS_PER_COUNT_RESET, NOMINAL_RPM_RESET, CAPACITY_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_tog <= ~hold_tog;
        send_req(REQ_BEGIN, '0, '0);
        repeat (40)
            send_req(REQ_FLUX, pick_flux_delta(4), RPM_W'($urandom));
        send_req(REQ_END, '0, '0);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_tog != hold_seen)
        begin
            hold_seen <= hold_tog;
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic compare_field(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what,
                     want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        flux_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, kind %0d", $time, kind);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("kind", 32'(want.kind), 32'(kind));
                compare_field("timestamp_ns", want.stamp, timestamp_ns);
                compare_field("stored", 32'(want.stored), 32'(stored));
                compare_field("overflow", 32'(want.overflow), 32'(overflow));
                compare_field("cell_width_ns", 32'(want.cell_width), 32'(cell_width_ns));
            end
        end
    end

    initial
    begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_NS_PER_COUNT;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = REQ_BEGIN;
        delta      = '0;
        actual_rpm = '0;
        reg_ns_per_count = NS_PER_COUNT_RESET;
        reg_nominal_rpm  = NOMINAL_RPM_RESET;
        reg_capacity     = CAPACITY_RESET;
        clear_run_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_events();
        test_register_extremes();
        test_random_streams();
        test_output_backpressure();

        // drain, then give the block time to show any stray result
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
